// ===== hw/rtl/binary_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the binary_to_decimal_ascii RTL.
// No dependencies; included by binary_to_decimal_ascii, which checks its own logic.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bda assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bda assertion failed");

`endif

// ===== hw/rtl/bda_pkg.sv =====
// Types and constants for the binary to decimal ASCII converter.
// No dependencies; used by bda_cell and binary_to_decimal_ascii.
package bda_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int ASCII_W    = 6;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0]  LEFT_FULL  = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0]  LEFT_ONE   = LEFT_W'(1);
    localparam logic [ASCII_W-1:0] ASCII_ZERO = ASCII_W'(48);
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DIGIT_THREE = DIGIT_W'(3);
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/bda_cell.sv =====
// One BCD digit cell of the double-dabble chain.
// Depends on bda_pkg.
module bda_cell (
    input  logic                         i_clk,
    input  bda_pkg::t_cell_ctrl          i_ctrl,
    input  logic                         i_bit,
    input  logic [bda_pkg::DIGIT_W-1:0]  i_digit,
    output logic                         o_carry,
    output logic [bda_pkg::DIGIT_W-1:0]  o_digit
);

    logic [bda_pkg::DIGIT_W-1:0] r_digit;
    logic [bda_pkg::DIGIT_W-1:0] n_digit;
    logic [bda_pkg::DIGIT_W-1:0] w_adj;

    // Add three before the shift so that a digit of five or more carries out.
    assign w_adj   = (r_digit >= bda_pkg::DIGIT_FIVE) ? r_digit + bda_pkg::DIGIT_THREE
                                                       : r_digit;
    assign o_carry = w_adj[bda_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        case (i_ctrl.op)
            bda_pkg::OP_CLEAR:  n_digit = '0;
            bda_pkg::OP_DABBLE: n_digit = {w_adj[bda_pkg::DIGIT_W-2:0], i_bit};
            bda_pkg::OP_SHIFT:  n_digit = i_digit;
            default:            n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter: control and digit chain.
// Depends on bda_pkg, bda_cell and binary_to_decimal_ascii_defines.svh.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | i_valid, o_stall, i_value[31:0]       | in
//   output  | o_valid, i_stall, o_ascii_digit[5:0], | out
//           | o_last_digit                          |
//
// Each value passes through the transfer, a double-dabble phase that shifts the
// 32 input bits through the ten-cell digit chain (one input bit per cycle), and
// a scan of the ten digits that drops leading zeros or sends a digit. A stall
// on the output only lengthens the scan phase. Reset is synchronous and active
// low and returns the controller to idle with the output empty; the digit cells
// need no reset.
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bda_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bda_pkg::ASCII_W-1:0]  o_ascii_digit,
    output logic                         o_last_digit
);

    bda_pkg::t_state     r_state;
    bda_pkg::t_state     n_state;
    bda_pkg::t_cell_ctrl w_ctrl;

    // Binary shift register that feeds the chain, MSB first.
    logic [bda_pkg::VALUE_W-1:0] r_bin;
    logic [bda_pkg::CNT_W-1:0]   r_cnt;
    // Digits still held in the chain during the scan, and the flag that says
    // no nonzero digit has been sent yet.
    logic [bda_pkg::LEFT_W-1:0]  r_left;
    logic                        r_lead;

    logic                         r_out_valid;
    logic [bda_pkg::ASCII_W-1:0]  r_out_ascii;
    logic                         r_out_last;

    logic w_accept;
    logic w_out_free;
    logic w_skip;
    logic w_load_out;

    // Chain wiring: index i feeds cell i, index NUM_DIGITS is the top output.
    logic                        w_carry [bda_pkg::NUM_DIGITS+1];
    logic [bda_pkg::DIGIT_W-1:0] w_digit [bda_pkg::NUM_DIGITS+1];

    assign w_carry[0] = r_bin[bda_pkg::VALUE_W-1];
    assign w_digit[0] = '0;

    for (genvar g = 0; g < bda_pkg::NUM_DIGITS; g++) begin : g_cell
        bda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   (w_carry[g]),
            .i_digit (w_digit[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    assign o_stall    = (r_state != bda_pkg::ST_IDLE);
    assign w_accept   = i_valid && (r_state == bda_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    // A leading zero is dropped, except the units digit, so that zero prints.
    assign w_skip     = r_lead && (w_digit[bda_pkg::NUM_DIGITS] == '0)
                        && (r_left != bda_pkg::LEFT_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_ctrl.op  = bda_pkg::OP_HOLD;
        w_load_out = 1'b0;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                if (i_valid) begin
                    w_ctrl.op = bda_pkg::OP_CLEAR;
                    n_state   = bda_pkg::ST_CONVERT;
                end
            end
            bda_pkg::ST_CONVERT: begin
                w_ctrl.op = bda_pkg::OP_DABBLE;
                if (r_cnt == bda_pkg::CNT_LAST) begin
                    n_state = bda_pkg::ST_EMIT;
                end
            end
            bda_pkg::ST_EMIT: begin
                if (w_skip) begin
                    w_ctrl.op = bda_pkg::OP_SHIFT;
                end else if (w_out_free) begin
                    w_ctrl.op  = bda_pkg::OP_SHIFT;
                    w_load_out = 1'b1;
                    if (r_left == bda_pkg::LEFT_ONE) begin
                        n_state = bda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = bda_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencing counters and the binary shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_left <= '0;
            r_lead <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == bda_pkg::ST_CONVERT) begin
                r_cnt <= r_cnt + bda_pkg::CNT_W'(1);
            end
            if (r_state == bda_pkg::ST_CONVERT && r_cnt == bda_pkg::CNT_LAST) begin
                r_left <= bda_pkg::LEFT_FULL;
                r_lead <= 1'b1;
            end else if (w_ctrl.op == bda_pkg::OP_SHIFT) begin
                r_left <= r_left - bda_pkg::LEFT_ONE;
                if (w_load_out) begin
                    r_lead <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin <= i_value;
        end else if (r_state == bda_pkg::ST_CONVERT) begin
            r_bin <= {r_bin[bda_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    // Output register: it holds a digit until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_ascii <= bda_pkg::ASCII_ZERO
                           + {{(bda_pkg::ASCII_W-bda_pkg::DIGIT_W){1'b0}},
                              w_digit[bda_pkg::NUM_DIGITS]};
            r_out_last  <= (r_left == bda_pkg::LEFT_ONE);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ascii_digit = r_out_ascii;
    assign o_last_digit  = r_out_last;

    // Ten digits always hold a 32-bit value, so nothing carries out the top.
    `BDA_ASSERT_SAME(a_no_top_carry, i_clk, i_rst_n,
        r_state == bda_pkg::ST_CONVERT, !w_carry[bda_pkg::NUM_DIGITS])
    // Every digit leaving the chain is a decimal digit.
    `BDA_ASSERT_SAME(a_top_is_decimal, i_clk, i_rst_n,
        r_state == bda_pkg::ST_EMIT, w_digit[bda_pkg::NUM_DIGITS] <= bda_pkg::DIGIT_NINE)
    // A transfer in always starts a conversion.
    `BDA_ASSERT_NEXT(a_accept_converts, i_clk, i_rst_n,
        w_accept, r_state == bda_pkg::ST_CONVERT)

endmodule
